// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of the geometry encoder.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define VTGE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vtge: assertion failed");

// Check a property at every rising edge, reset included.
`define VTGE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("vtge: assertion failed during or after reset");

`endif

// ===== hdl/vtge_pkg.sv =====
// Package of the vector tile geometry encoder: kind codes, command ids, helpers.
// No dependencies; imported by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package vtge_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 29;
  localparam int unsigned NumSlot = 5;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    KindPoint  = 2'd0,
    KindLine   = 2'd1,
    KindRing   = 2'd2,
    KindUnused = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CmdMoveTo = 3'd1,
    CmdLineTo = 3'd2,
    CmdClose  = 3'd7
  } cmd_e;

  // Command header: id in the low three bits, count above it.
  function automatic word_t header_word(cmd_e id, count_t count);
    return {count, id};
  endfunction

  // Zigzag: shift left, flip all bits when the delta is negative.
  function automatic word_t zigzag(word_t d);
    return {d[WordW-2:0], 1'b0} ^ {WordW{d[WordW-1]}};
  endfunction

endpackage

// ===== hdl/vector_tile_geometry_encoder_unit.sv =====
// Top level of the vector tile geometry encoder: vertex in, geometry words out.
// Depends on vtge_pkg.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid_i / in_ready_o): one vertex per transfer, with its
//   geometry kind, feature and path marks, path vertex count and coordinates.
//   Output channel (out_valid_o / out_ready_i): one 32-bit geometry word per
//   transfer; last_word_o marks the final word caused by a vertex.
//   A vertex gives 2 to 5 words: MoveTo header on a path start, zigzag dx and
//   dy, LineTo header on a line or ring start, ClosePath on a ring end.
//   Kind 3 is taken and dropped: no words, cursor untouched.
// Data flow
//   The first word of a vertex passes through the word buffer, then the output
//   register. Words leave at one per cycle while the receiver is ready, a rate
//   that the single output port sets. The next vertex is taken in the cycle its
//   predecessor's last word moves into the output register, so the port stays
//   busy back to back.
// Reset and stall
//   Reset clears the cursor to the origin and empties both the word buffer and
//   the output register. When the receiver stalls, the output word holds, the
//   buffer holds, and in_ready_o drops once the buffer is full.

module vector_tile_geometry_encoder_unit #(
  parameter int unsigned MAX_PATH_POINTS = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          geom_kind_i,
  input  logic                feature_start_i,
  input  logic                path_start_i,
  input  logic                path_end_i,
  input  logic [15:0]         path_points_i,
  input  logic signed [31:0]  x_coord_i,
  input  logic signed [31:0]  y_coord_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vtge_pkg::word_t     geom_word_o,
  output logic                last_word_o
);
  import vtge_pkg::*;

  localparam count_t MaxPts = count_t'(MAX_PATH_POINTS);

  // Cursor: the previous vertex.
  word_t cursor_x_q, cursor_x_d;
  word_t cursor_y_q, cursor_y_d;

  // Word buffer: all words of one vertex, drained one per cycle while the output register is free.
  word_t      words_q [NumSlot];
  word_t      words_d [NumSlot];
  logic [2:0] n_q, n_d;
  logic [2:0] idx_q;
  logic       buf_valid_q;

  // Output register.
  logic  out_valid_q;
  word_t out_word_q;
  logic  out_last_q;

  kind_e  kind;
  logic   in_xfer;
  logic   pop;
  logic   pop_last;
  count_t pts_sat;
  count_t line_cnt;
  word_t  base_x, base_y;
  word_t  dx_word, dy_word;
  word_t  move_hdr, line_hdr, close_hdr;
  logic   is_line_like;
  logic   do_close;

  assign kind = kind_e'(geom_kind_i);

  // Move a word from the buffer whenever the output register is free or leaving.
  assign pop      = buf_valid_q && (!out_valid_q || out_ready_i);
  assign pop_last = pop && (idx_q == (n_q - 3'd1));

  // Take a vertex when the buffer is empty or hands over its last word now.
  assign in_ready_o = !buf_valid_q || pop_last;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Clamp the count to the configured limit; LineTo carries count minus one.
  always_comb begin
    pts_sat  = (count_t'(path_points_i) > MaxPts) ? MaxPts : count_t'(path_points_i);
    line_cnt = (pts_sat == '0) ? '0 : pts_sat - count_t'(1);
  end

  // A feature start measures this vertex from the origin.
  assign base_x  = feature_start_i ? '0 : cursor_x_q;
  assign base_y  = feature_start_i ? '0 : cursor_y_q;
  assign dx_word = zigzag(word_t'(x_coord_i) - base_x);
  assign dy_word = zigzag(word_t'(y_coord_i) - base_y);

  assign is_line_like = (kind == KindLine) || (kind == KindRing);
  assign do_close     = path_end_i && (kind == KindRing);

  assign move_hdr  = header_word(CmdMoveTo, (kind == KindPoint) ? pts_sat : count_t'(1));
  assign line_hdr  = header_word(CmdLineTo, line_cnt);
  assign close_hdr = header_word(CmdClose, count_t'(1));

  // Lay the words out in stream order and count them.
  always_comb begin
    if (path_start_i) begin
      words_d[0] = move_hdr;
      words_d[1] = dx_word;
      words_d[2] = dy_word;
      words_d[3] = is_line_like ? line_hdr : close_hdr;
      words_d[4] = close_hdr;
    end else begin
      words_d[0] = dx_word;
      words_d[1] = dy_word;
      words_d[2] = close_hdr;
      words_d[3] = close_hdr;
      words_d[4] = close_hdr;
    end
    if (kind == KindUnused) begin
      n_d = '0;
    end else begin
      n_d = 3'd2 + {2'b00, path_start_i} + {2'b00, path_start_i && is_line_like}
          + {2'b00, do_close};
    end
  end

  // Advance the cursor on every vertex that is not dropped.
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (in_xfer && (kind != KindUnused)) begin
      cursor_x_d = word_t'(x_coord_i);
      cursor_y_d = word_t'(y_coord_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // Buffer control: load on a transfer, step on each pop, empty after the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      if (in_xfer && (n_d != '0)) begin
        buf_valid_q <= 1'b1;
        idx_q       <= '0;
        n_q         <= n_d;
      end else if (pop_last) begin
        buf_valid_q <= 1'b0;
      end else if (pop) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // Buffer payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (n_d != '0)) begin
      for (int i = 0; i < NumSlot; i++) begin
        words_q[i] <= words_d[i];
      end
    end
  end

  // Output register: hold while stalled, refill from the buffer, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_word_q <= words_q[idx_q];
      out_last_q <= pop_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign geom_word_o = out_word_q;
  assign last_word_o = out_last_q;

endmodule

// ===== hdl/vtge_checker.sv =====
// Port-level checker for the geometry encoder, bound to the top level.
// Depends on vtge_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vtge_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          geom_kind_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [31:0]         geom_word_o,
  input logic                last_word_o
);
  import vtge_pkg::*;

  // A stalled word holds its value and mark.
  `VTGE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(geom_word_o) && $stable(last_word_o))

  // Nothing is offered in the cycle after reset is seen.
  `VTGE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)

  // A taken vertex fills the buffer with at least two words: no new vertex next cycle.
  `VTGE_ASSERT(a_busy_after_vertex, in_valid_i && in_ready_o && (geom_kind_i != KindUnused) |=> !in_ready_o)

  // Words of one vertex follow each other without a gap.
  `VTGE_ASSERT(a_no_gap, out_valid_o && out_ready_i && !last_word_o |=> out_valid_o)

endmodule

bind vector_tile_geometry_encoder_unit vtge_checker u_vtge_checker (.*);

// ===== test/vector_tile_geometry_encoder_unit_test.sv =====
// Self-checking testbench for vector_tile_geometry_encoder_unit: vertices in, geometry words out.
// Depends on vtge_pkg and the encoder RTL only; drives a directed table, then random features.
`timescale 1ns / 1ps

module vector_tile_geometry_encoder_unit_test;
  import vtge_pkg::*;

  localparam int unsigned MaxPathPoints = 65535;
  localparam int          NumDirected   = 23;
  localparam int          RandomItems   = 250;
  localparam int          DrainCycles   = 24;
  localparam int          CycleLimit    = 200000;

  // One vertex as the block sees it on its input port.
  typedef struct packed {
    kind_e       kind;
    logic        fstart;
    logic        pstart;
    logic        pend;
    logic [15:0] pts;
    logic [31:0] x;
    logic [31:0] y;
  } vertex_t;

  // Up to five words per vertex; index 0 is the first word to leave.
  typedef logic [0:NumSlot-1][31:0] word_list_t;

  // Directed row: where typed is set, the listed words are the expectation.
  typedef struct packed {
    vertex_t    v;
    logic       typed;
    logic [2:0] typed_n;
    word_list_t typed_w;
  } stim_row_t;

  typedef struct packed {
    word_t word;
    logic  last_flag;
  } geom_out_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [1:0]         geom_kind_i     = 2'd0;
  logic               feature_start_i = 1'b0;
  logic               path_start_i    = 1'b0;
  logic               path_end_i      = 1'b0;
  logic [15:0]        path_points_i   = 16'd0;
  logic signed [31:0] x_coord_i       = 32'sd0;
  logic signed [31:0] y_coord_i       = 32'sd0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  word_t              geom_word_o;
  logic               last_word_o;

  // Pen position of the encoder as the predictor tracks it.
  word_t pen_x = '0;
  word_t pen_y = '0;

  geom_out_t pending_words[$];
  int        failures    = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;
  int        stall_mode  = 0;
  int        stall_left  = 0;

  localparam word_list_t NoWords = '0;

  // Directed part: reset state, extremes, the unused kind, ignored path ends,
  // delta wrap-round, zero counts, ring closing and the cursor carried across paths.
  stim_row_t directed_table [NumDirected] = '{
    // first line after reset: MoveTo, dx, dy, LineTo with count two
    '{'{KindLine, 1'b0, 1'b1, 1'b0, 16'd3, 32'd5, 32'hFFFF_FFFD},
      1'b1, 3'd4, {32'h9, 32'hA, 32'h5, 32'h12, 32'h0}},
    '{'{KindLine, 1'b0, 1'b0, 1'b0, 16'd0, 32'd6, 32'd0}, 1'b0, 3'd0, NoWords},
    // path end on a line is ignored
    '{'{KindLine, 1'b0, 1'b0, 1'b1, 16'hFFFF, 32'd2, 32'h10}, 1'b0, 3'd0, NoWords},
    // largest count, largest positive and most negative deltas
    '{'{KindPoint, 1'b1, 1'b1, 1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000},
      1'b1, 3'd3, {32'h0007_FFF9, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 32'h0}},
    // unused kind: no words, cursor kept even with a feature start
    '{'{KindUnused, 1'b1, 1'b1, 1'b1, 16'hFFFF, 32'd0, 32'd0}, 1'b1, 3'd0, NoWords},
    // deltas wrap modulo 2^32; path end on a point set is ignored
    '{'{KindPoint, 1'b0, 1'b0, 1'b1, 16'd1, 32'h8000_0000, 32'h7FFF_FFFF},
      1'b1, 3'd2, {32'h2, 32'h1, 32'h0, 32'h0, 32'h0}},
    // one-vertex ring: all five words
    '{'{KindRing, 1'b1, 1'b1, 1'b1, 16'd1, 32'd0, 32'd0},
      1'b1, 3'd5, {32'h9, 32'h0, 32'h0, 32'h2, 32'hF}},
    // point set header with count zero
    '{'{KindPoint, 1'b1, 1'b1, 1'b0, 16'd0, 32'hFFFF_FFFF, 32'd1},
      1'b1, 3'd3, {32'h1, 32'h1, 32'h2, 32'h0, 32'h0}},
    // LineTo count saturates at zero
    '{'{KindLine, 1'b0, 1'b1, 1'b0, 16'd0, 32'd100, 32'd200}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b1, 1'b1, 1'b0, 16'd4, 32'd10, 32'd10}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b0, 16'd4, 32'd20, 32'd10}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b0, 16'd4, 32'd20, 32'd20}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b1, 16'd4, 32'd10, 32'd20}, 1'b0, 3'd0, NoWords},
    // second ring of the same feature starts from the previous ring's end
    '{'{KindRing, 1'b0, 1'b1, 1'b0, 16'd3, 32'd12, 32'd12}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b0, 16'd3, 32'd18, 32'd12}, 1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b1, 16'd3, 32'd12, 32'd18}, 1'b0, 3'd0, NoWords},
    '{'{KindUnused, 1'b0, 1'b0, 1'b0, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA},
      1'b0, 3'd0, NoWords},
    '{'{KindPoint, 1'b0, 1'b1, 1'b0, 16'd2, 32'h8000_0000, 32'h8000_0000},
      1'b0, 3'd0, NoWords},
    '{'{KindPoint, 1'b0, 1'b0, 1'b1, 16'hAAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      1'b0, 3'd0, NoWords},
    '{'{KindLine, 1'b1, 1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b0, 3'd0, NoWords},
    '{'{KindLine, 1'b0, 1'b1, 1'b0, 16'h8000, 32'hAAAA_AAAA, 32'h5555_5555},
      1'b0, 3'd0, NoWords},
    '{'{KindRing, 1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0}, 1'b0, 3'd0, NoWords},
    // feature start in the middle of a ring clears the cursor
    '{'{KindRing, 1'b1, 1'b0, 1'b1, 16'd7, 32'd3, 32'd4}, 1'b0, 3'd0, NoWords}
  };

  vector_tile_geometry_encoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .geom_kind_i    (geom_kind_i),
    .feature_start_i(feature_start_i),
    .path_start_i   (path_start_i),
    .path_end_i     (path_end_i),
    .path_points_i  (path_points_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .geom_word_o    (geom_word_o),
    .last_word_o    (last_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Command header: id in the low three bits, count shifted above it.
  function automatic word_t command_header(cmd_e id, logic [31:0] count);
    return (word_t'(id) & 32'h7) | (count << 3);
  endfunction

  // Fold the sign into bit zero so small deltas give small words.
  function automatic word_t to_zigzag(word_t d);
    return (d << 1) ^ {32{d[31]}};
  endfunction

  // Work out the words one vertex causes and advance the pen.
  function automatic int encode_vertex(input vertex_t v, output word_list_t words);
    logic [31:0] count;
    int          n;
    words = '0;
    n     = 0;
    if (v.kind == KindUnused) return 0;
    count = (32'(v.pts) > MaxPathPoints) ? MaxPathPoints : 32'(v.pts);
    if (v.fstart) begin
      pen_x = '0;
      pen_y = '0;
    end
    if (v.pstart) begin
      words[n] = command_header(CmdMoveTo, (v.kind == KindPoint) ? count : 32'd1);
      n++;
    end
    words[n]     = to_zigzag(v.x - pen_x);
    words[n + 1] = to_zigzag(v.y - pen_y);
    n += 2;
    pen_x = v.x;
    pen_y = v.y;
    if (v.pstart && v.kind != KindPoint) begin
      words[n] = command_header(CmdLineTo, (count > 0) ? count - 1 : 32'd0);
      n++;
    end
    if (v.pend && v.kind == KindRing) begin
      words[n] = command_header(CmdClose, 32'd1);
      n++;
    end
    return n;
  endfunction

  // Offer one vertex in the sender's burst pattern, hold it until the transfer,
  // then queue the words it should cause.
  task automatic send_vertex(input vertex_t v, input logic typed, input int typed_n,
                             input word_list_t typed_w);
    word_list_t words;
    int         n;
    int         gap;
    int         k;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // a third of the bursts follow straight on, giving stretches with no gaps
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    geom_kind_i     <= v.kind;
    feature_start_i <= v.fstart;
    path_start_i    <= v.pstart;
    path_end_i      <= v.pend;
    path_points_i   <= v.pts;
    x_coord_i       <= v.x;
    y_coord_i       <= v.y;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    n = encode_vertex(v, words);
    if (typed) begin
      n     = typed_n;
      words = typed_w;
    end
    for (k = 0; k < n; k++) pending_words.push_back('{word: words[k], last_flag: (k == n - 1)});
  endtask

  function automatic word_t extreme_coord();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly small steps from the last vertex, sometimes a jump anywhere or to an extreme.
  function automatic word_t next_coord(word_t base);
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return extreme_coord();
      default: return base + word_t'($urandom_range(0, 511)) - 32'd256;
    endcase
  endfunction

  function automatic vertex_t noise_vertex();
    vertex_t v;
    v.kind   = kind_e'($urandom_range(0, 3));
    v.fstart = 1'($urandom_range(0, 1));
    v.pstart = 1'($urandom_range(0, 1));
    v.pend   = 1'($urandom_range(0, 1));
    v.pts    = 16'($urandom);
    v.x      = $urandom;
    v.y      = $urandom;
    return v;
  endfunction

  // Well-formed features with random content, salted with stray and unused-kind vertices.
  task automatic send_random_features();
    vertex_t v;
    kind_e   kind;
    word_t   gx;
    word_t   gy;
    int      counted;
    int      n_paths;
    int      len;
    int      p;
    int      i;
    counted = 0;
    while (counted < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        v = noise_vertex();
        send_vertex(v, 1'b0, 0, NoWords);
        if (v.kind != KindUnused) counted++;
      end else begin
        kind    = kind_e'($urandom_range(0, 2));
        n_paths = (kind == KindPoint) ? 1 : $urandom_range(1, 3);
        gx      = '0;
        gy      = '0;
        for (p = 0; p < n_paths; p++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
          for (i = 0; i < len; i++) begin
            gx       = next_coord(gx);
            gy       = next_coord(gy);
            v.kind   = kind;
            v.fstart = (p == 0 && i == 0);
            v.pstart = (i == 0);
            v.pend   = (i == len - 1);
            // the count matters on a path start only; elsewhere it is random filler
            if (i == 0 && $urandom_range(0, 7) != 0) v.pts = 16'(len);
            else v.pts = 16'($urandom);
            v.x = gx;
            v.y = gy;
            send_vertex(v, 1'b0, 0, NoWords);
            counted++;
            // drop an unused-kind vertex into the path now and then
            if ($urandom_range(0, 15) == 0) begin
              v      = noise_vertex();
              v.kind = KindUnused;
              send_vertex(v, 1'b0, 0, NoWords);
            end
          end
        end
      end
    end
  endtask

  // Receiver: switch between always ready, coin-toss and mostly stalled stretches.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare every output transfer with the oldest word still owed.
  always @(posedge clk_i) begin : word_check
    geom_out_t owed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("geom_word: expected none, got %h", geom_word_o);
        failures++;
      end else begin
        owed = pending_words.pop_front();
        if (geom_word_o !== owed.word) begin
          $error("geom_word: expected %h, got %h", owed.word, geom_word_o);
          failures++;
        end
        if (last_word_o !== owed.last_flag) begin
          $error("last_word: expected %b, got %b", owed.last_flag, last_word_o);
          failures++;
        end
      end
    end
  end

  // Hard stop well past the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("vector_tile_geometry_encoder_unit_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int row;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (row = 0; row < NumDirected; row++) begin
      send_vertex(directed_table[row].v, directed_table[row].typed,
                  int'(directed_table[row].typed_n), directed_table[row].typed_w);
    end
    send_random_features();
    in_valid_i <= 1'b0;
    // drain what is owed, then watch a while longer for stray words
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("vector_tile_geometry_encoder_unit_test: PASS");
    end else begin
      $display("vector_tile_geometry_encoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/vtge_pkg.sv
hdl/vector_tile_geometry_encoder_unit.sv
hdl/vtge_checker.sv
test/vector_tile_geometry_encoder_unit_test.sv
